[hdl/taosf_pkg.sv]
// Shared types, constants, microcode program and rounding helper for the observer block.
package taosf_pkg;

   // Fixed-point and datapath widths.
   localparam int Q_W      = 16;
   localparam int Q_FRAC   = 12;
   localparam int INNOV_W  = Q_W + 1;
   localparam int PROD_W   = Q_W + INNOV_W;
   localparam int ACC_W    = PROD_W + 3;
   localparam int LIMIT_W  = 15;
   localparam int MASK_W   = 2;
   localparam int STEP_W   = 5;
   localparam int CSR_AW   = 6;
   localparam int CSR_DW   = 64;
   localparam int GAINS_W  = 48;
   localparam int WORD_W   = 32;

   localparam logic [STEP_W-1:0] STEP_IDLE = '0;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_CONTROL_GAINS,
      REG_TRANSITION_ROW0,
      REG_TRANSITION_ROW1,
      REG_INPUT_GAINS,
      REG_OBSERVER_GAINS,
      REG_SERVO_LIMIT,
      REG_PLATE_RATIO,
      REG_INVERT_MASK
   } reg_index_type;

   // Coefficient operand of the multiplier.
   typedef enum logic [3:0] {
      CO_GREF, CO_K0, CO_K1, CO_RATIO,
      CO_F00, CO_F01, CO_F10, CO_F11,
      CO_G0, CO_G1, CO_L0, CO_L1
   } coef_sel_type;

   // Signal operand of the multiplier.
   typedef enum logic [2:0] {
      OP_REF, OP_MEAS, OP_EST0, OP_EST1, OP_CMD, OP_CLAMP, OP_INNOV
   } opnd_sel_type;

   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_type;

   typedef enum logic [2:0] {WB_NONE, WB_CMD, WB_ANG, WB_EST0, WB_EST1} wb_type;

   typedef enum logic [1:0] {JMP_NEXT, JMP_WAIT_START, JMP_WAIT_OUT, JMP_RESTART} jump_type;

   // One microcode word.
   typedef struct packed {
      coef_sel_type a_sel;
      opnd_sel_type b_sel;
      acc_op_type   acc_op;
      wb_type       wb;
      jump_type     jump;
   } ucode_type;

   // Control word broadcast from the sequencer to both axis lanes.
   typedef struct packed {
      logic         start;
      coef_sel_type a_sel;
      opnd_sel_type b_sel;
      acc_op_type   acc_op;
      wb_type       wb;
   } lane_ctl_type;

   // Coefficients shared by both axes.
   typedef struct packed {
      logic signed [Q_W-1:0] gref;
      logic signed [Q_W-1:0] k0;
      logic signed [Q_W-1:0] k1;
      logic signed [Q_W-1:0] f00;
      logic signed [Q_W-1:0] f01;
      logic signed [Q_W-1:0] f10;
      logic signed [Q_W-1:0] f11;
      logic signed [Q_W-1:0] g0;
      logic signed [Q_W-1:0] g1;
      logic signed [Q_W-1:0] l0;
      logic signed [Q_W-1:0] l1;
      logic signed [Q_W-1:0] ratio;
      logic [LIMIT_W-1:0]    limit;
   } coef_type;

   // Control program. The product of step n is accumulated in step n+1, and a
   // write-back takes the accumulator as it stood at the start of its step.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type uc;
      uc = '{CO_GREF, OP_REF, ACC_HOLD, WB_NONE, JMP_NEXT};
      case (step)
         5'd0:  uc = '{CO_GREF,  OP_REF,   ACC_HOLD, WB_NONE, JMP_WAIT_START};
         5'd1:  uc = '{CO_GREF,  OP_REF,   ACC_HOLD, WB_NONE, JMP_NEXT};
         5'd2:  uc = '{CO_K0,    OP_MEAS,  ACC_LOAD, WB_NONE, JMP_NEXT};
         5'd3:  uc = '{CO_K1,    OP_EST1,  ACC_SUB,  WB_NONE, JMP_NEXT};
         5'd4:  uc = '{CO_GREF,  OP_REF,   ACC_SUB,  WB_NONE, JMP_NEXT};
         5'd5:  uc = '{CO_GREF,  OP_REF,   ACC_HOLD, WB_CMD,  JMP_NEXT};
         5'd6:  uc = '{CO_RATIO, OP_CMD,   ACC_HOLD, WB_NONE, JMP_NEXT};
         5'd7:  uc = '{CO_F00,   OP_EST0,  ACC_LOAD, WB_NONE, JMP_NEXT};
         5'd8:  uc = '{CO_F01,   OP_EST1,  ACC_LOAD, WB_ANG,  JMP_NEXT};
         5'd9:  uc = '{CO_G0,    OP_CLAMP, ACC_ADD,  WB_NONE, JMP_NEXT};
         5'd10: uc = '{CO_L0,    OP_INNOV, ACC_ADD,  WB_NONE, JMP_NEXT};
         5'd11: uc = '{CO_F10,   OP_EST0,  ACC_ADD,  WB_NONE, JMP_NEXT};
         5'd12: uc = '{CO_F11,   OP_EST1,  ACC_LOAD, WB_EST0, JMP_NEXT};
         5'd13: uc = '{CO_G1,    OP_CLAMP, ACC_ADD,  WB_NONE, JMP_NEXT};
         5'd14: uc = '{CO_L1,    OP_INNOV, ACC_ADD,  WB_NONE, JMP_NEXT};
         5'd15: uc = '{CO_GREF,  OP_REF,   ACC_ADD,  WB_NONE, JMP_NEXT};
         5'd16: uc = '{CO_GREF,  OP_REF,   ACC_HOLD, WB_EST1, JMP_NEXT};
         5'd17: uc = '{CO_GREF,  OP_REF,   ACC_HOLD, WB_NONE, JMP_WAIT_OUT};
         default: uc = '{CO_GREF, OP_REF,  ACC_HOLD, WB_NONE, JMP_RESTART};
      endcase
      return uc;
   endfunction

   // Round a Q11.24 sum to Q3.12 (add half, floor), optionally negate, saturate.
   function automatic logic signed [Q_W-1:0] round_sat(
      input logic signed [ACC_W-1:0] acc,
      input logic                    neg
   );
      logic signed [ACC_W:0]        v;
      logic signed [ACC_W-Q_FRAC:0] q;
      logic signed [ACC_W-Q_FRAC+1:0] r;
      v = (ACC_W+1)'(acc) + (ACC_W+1)'(1 <<< (Q_FRAC - 1));
      q = v[ACC_W:Q_FRAC];
      r = neg ? -((ACC_W-Q_FRAC+2)'(q)) : (ACC_W-Q_FRAC+2)'(q);
      if (r > (ACC_W-Q_FRAC+2)'(32767)) begin
         return 16'sh7FFF;
      end else if (r < -(ACC_W-Q_FRAC+2)'(32768)) begin
         return 16'sh8000;
      end
      return r[Q_W-1:0];
   endfunction

endpackage

[hdl/taosf_csr.sv]
// Configuration register file with an APB-style write and read port.
module taosf_csr
   import taosf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output coef_type          coef,
   output logic [MASK_W-1:0] invert_mask
);

   logic [GAINS_W-1:0] control_gains_ff;
   logic [WORD_W-1:0]  transition_row0_ff;
   logic [WORD_W-1:0]  transition_row1_ff;
   logic [WORD_W-1:0]  input_gains_ff;
   logic [WORD_W-1:0]  observer_gains_ff;
   logic [LIMIT_W-1:0] servo_limit_ff;
   logic [Q_W-1:0]     plate_ratio_ff;
   logic [MASK_W-1:0]  invert_mask_ff;
   reg_index_type      index;
   logic               write_en;

   // Registers sit at eight-byte spacing.
   assign index      = reg_index_type'(csr_paddr[CSR_AW-1:3]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         control_gains_ff   <= '0;
         transition_row0_ff <= '0;
         transition_row1_ff <= '0;
         input_gains_ff     <= '0;
         observer_gains_ff  <= '0;
         servo_limit_ff     <= LIMIT_W'(32767);
         plate_ratio_ff     <= Q_W'(4096);
         invert_mask_ff     <= '0;
      end else if (write_en) begin
         case (index)
            REG_CONTROL_GAINS:   control_gains_ff   <= csr_pwdata[GAINS_W-1:0];
            REG_TRANSITION_ROW0: transition_row0_ff <= csr_pwdata[WORD_W-1:0];
            REG_TRANSITION_ROW1: transition_row1_ff <= csr_pwdata[WORD_W-1:0];
            REG_INPUT_GAINS:     input_gains_ff     <= csr_pwdata[WORD_W-1:0];
            REG_OBSERVER_GAINS:  observer_gains_ff  <= csr_pwdata[WORD_W-1:0];
            REG_SERVO_LIMIT:     servo_limit_ff     <= csr_pwdata[LIMIT_W-1:0];
            REG_PLATE_RATIO:     plate_ratio_ff     <= csr_pwdata[Q_W-1:0];
            REG_INVERT_MASK:     invert_mask_ff     <= csr_pwdata[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // Read-back.
   always_comb begin
      case (index)
         REG_CONTROL_GAINS:   csr_prdata = CSR_DW'(control_gains_ff);
         REG_TRANSITION_ROW0: csr_prdata = CSR_DW'(transition_row0_ff);
         REG_TRANSITION_ROW1: csr_prdata = CSR_DW'(transition_row1_ff);
         REG_INPUT_GAINS:     csr_prdata = CSR_DW'(input_gains_ff);
         REG_OBSERVER_GAINS:  csr_prdata = CSR_DW'(observer_gains_ff);
         REG_SERVO_LIMIT:     csr_prdata = CSR_DW'(servo_limit_ff);
         REG_PLATE_RATIO:     csr_prdata = CSR_DW'(plate_ratio_ff);
         REG_INVERT_MASK:     csr_prdata = CSR_DW'(invert_mask_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // Unpack the coefficient fields.
   always_comb begin
      coef.gref  = control_gains_ff[15:0];
      coef.k0    = control_gains_ff[31:16];
      coef.k1    = control_gains_ff[47:32];
      coef.f00   = transition_row0_ff[15:0];
      coef.f01   = transition_row0_ff[31:16];
      coef.f10   = transition_row1_ff[15:0];
      coef.f11   = transition_row1_ff[31:16];
      coef.g0    = input_gains_ff[15:0];
      coef.g1    = input_gains_ff[31:16];
      coef.l0    = observer_gains_ff[15:0];
      coef.l1    = observer_gains_ff[31:16];
      coef.ratio = plate_ratio_ff;
      coef.limit = servo_limit_ff;
   end

   assign invert_mask = invert_mask_ff;

endmodule

[hdl/taosf_seq.sv]
// Microcode sequencer: step counter, program table and jump control.
module taosf_seq
   import taosf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         out_free,
   output logic         idle,
   output logic         publish,
   output lane_ctl_type ctl
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   ucode_type         uc;

   assign uc      = ucode_rom(step_ff);
   assign idle    = (uc.jump == JMP_WAIT_START);
   assign publish = (uc.jump == JMP_WAIT_OUT) && out_free;

   // Next step from the jump field.
   always_comb begin
      case (uc.jump)
         JMP_NEXT:       step_in = step_ff + STEP_W'(1);
         JMP_WAIT_START: step_in = start ? step_ff + STEP_W'(1) : step_ff;
         JMP_WAIT_OUT:   step_in = out_free ? STEP_IDLE : step_ff;
         default:        step_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // Control word to the lanes.
   always_comb begin
      ctl.start  = idle && start;
      ctl.a_sel  = uc.a_sel;
      ctl.b_sel  = uc.b_sel;
      ctl.acc_op = uc.acc_op;
      ctl.wb     = uc.wb;
   end

endmodule

[hdl/taosf_lane.sv]
// One axis datapath: operand selects, multiplier, accumulator and observer state.
module taosf_lane
   import taosf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  lane_ctl_type          ctl,
   input  coef_type              coef,
   input  logic                  invert,
   input  logic signed [Q_W-1:0] ref_in,
   input  logic signed [Q_W-1:0] meas_in,
   output logic signed [Q_W-1:0] servo,
   output logic signed [Q_W-1:0] plate
);

   logic signed [Q_W-1:0]     ref_ff;
   logic signed [Q_W-1:0]     meas_ff;
   logic signed [INNOV_W-1:0] innov_ff;
   logic signed [Q_W-1:0]     est0_ff;
   logic signed [Q_W-1:0]     est1_ff;
   logic signed [Q_W-1:0]     cmd_ff;
   logic signed [Q_W-1:0]     ang_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   prod_ext;
   logic signed [Q_W-1:0]     a_op;
   logic signed [INNOV_W-1:0] b_op;
   logic signed [INNOV_W-1:0] cmd_ext;
   logic signed [INNOV_W-1:0] lim_ext;
   logic signed [Q_W-1:0]     clamped;
   logic signed [Q_W-1:0]     wb_value;

   // Clamp the command to the servo limit.
   assign cmd_ext = INNOV_W'(cmd_ff);
   assign lim_ext = $signed({2'b00, coef.limit});
   always_comb begin
      if (cmd_ext > lim_ext) begin
         clamped = lim_ext[Q_W-1:0];
      end else if (cmd_ext < -lim_ext) begin
         clamped = Q_W'(-lim_ext);
      end else begin
         clamped = cmd_ff;
      end
   end

   // Coefficient operand.
   always_comb begin
      case (ctl.a_sel)
         CO_GREF:  a_op = coef.gref;
         CO_K0:    a_op = coef.k0;
         CO_K1:    a_op = coef.k1;
         CO_RATIO: a_op = coef.ratio;
         CO_F00:   a_op = coef.f00;
         CO_F01:   a_op = coef.f01;
         CO_F10:   a_op = coef.f10;
         CO_F11:   a_op = coef.f11;
         CO_G0:    a_op = coef.g0;
         CO_G1:    a_op = coef.g1;
         CO_L0:    a_op = coef.l0;
         CO_L1:    a_op = coef.l1;
         default:  a_op = '0;
      endcase
   end

   // Signal operand.
   always_comb begin
      case (ctl.b_sel)
         OP_REF:   b_op = INNOV_W'(ref_ff);
         OP_MEAS:  b_op = INNOV_W'(meas_ff);
         OP_EST0:  b_op = INNOV_W'(est0_ff);
         OP_EST1:  b_op = INNOV_W'(est1_ff);
         OP_CMD:   b_op = INNOV_W'(cmd_ff);
         OP_CLAMP: b_op = INNOV_W'(clamped);
         OP_INNOV: b_op = innov_ff;
         default:  b_op = '0;
      endcase
   end

   assign prod_in  = PROD_W'(a_op) * PROD_W'(b_op);
   assign prod_ext = ACC_W'(prod_ff);

   // Accumulator takes the product registered in the previous step.
   always_comb begin
      case (ctl.acc_op)
         ACC_LOAD: acc_in = prod_ext;
         ACC_ADD:  acc_in = acc_ff + prod_ext;
         ACC_SUB:  acc_in = acc_ff - prod_ext;
         default:  acc_in = acc_ff;
      endcase
   end

   assign wb_value = round_sat(acc_ff, (ctl.wb == WB_CMD) && invert);

   // Working registers of the datapath.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (ctl.start) begin
         ref_ff   <= ref_in;
         meas_ff  <= meas_in;
         innov_ff <= INNOV_W'(meas_in) - INNOV_W'(est0_ff);
      end
      if (ctl.wb == WB_CMD) begin
         cmd_ff <= wb_value;
      end
      if (ctl.wb == WB_ANG) begin
         ang_ff <= wb_value;
      end
   end

   // Observer estimate, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         est0_ff <= '0;
         est1_ff <= '0;
      end else begin
         if (ctl.wb == WB_EST0) begin
            est0_ff <= wb_value;
         end
         if (ctl.wb == WB_EST1) begin
            est1_ff <= wb_value;
         end
      end
   end

   assign servo = clamped;
   assign plate = ang_ff;

endmodule

[hdl/two_axis_observer_state_feedback.sv]
// Two-axis state feedback controller with a second-order observer: top level.
//
// The req channel carries one sample tick: ref_x, meas_x, ref_y, meas_y, each
// signed Q3.12. For every accepted transaction the rsp channel delivers one
// result: the clamped servo commands and the plate angles of both axes.
// Coefficients, servo limit, plate ratio and invert mask are written through
// the csr port, by the user only while no sample is in flight (not enforced).
// A microcoded sequencer walks an 18-step program; both axes run the same
// control word in two lanes, each with one 16x17 multiplier and accumulator.
// The result is registered when the last step publishes it, and a new
// sample is taken only once the program is back at its idle step; the single
// multiply-accumulate per axis and its chain of dependent sums set the pace.
// Reset clears the sequencer, the output valid and the observer estimates,
// and loads the register reset values.
// When the receiver stalls, the result waits in the output register; the
// next sample can still be taken and computed, and its last step holds
// until the output register frees.
module two_axis_observer_state_feedback
   import taosf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [63:0]       req_tdata,   // ref_x, meas_x, ref_y, meas_y
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [63:0]       rsp_tdata,   // servo_x, servo_y, plate_x, plate_y
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   coef_type              coef;
   logic [MASK_W-1:0]     invert_mask;
   lane_ctl_type          ctl;
   logic                  idle;
   logic                  publish;
   logic                  out_free;
   logic                  start;
   logic signed [Q_W-1:0] servo_x;
   logic signed [Q_W-1:0] servo_y;
   logic signed [Q_W-1:0] plate_x;
   logic signed [Q_W-1:0] plate_y;
   logic                  rsp_valid_ff;
   logic [63:0]           rsp_data_ff;

   assign req_tready = idle;
   assign start      = req_tvalid && idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   taosf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef),
      .invert_mask (invert_mask)
   );

   taosf_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .idle     (idle),
      .publish  (publish),
      .ctl      (ctl)
   );

   taosf_lane u_lane_x (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .coef    (coef),
      .invert  (invert_mask[0]),
      .ref_in  (req_tdata[15:0]),
      .meas_in (req_tdata[31:16]),
      .servo   (servo_x),
      .plate   (plate_x)
   );

   taosf_lane u_lane_y (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .coef    (coef),
      .invert  (invert_mask[1]),
      .ref_in  (req_tdata[47:32]),
      .meas_in (req_tdata[63:48]),
      .servo   (servo_y),
      .plate   (plate_y)
   );

   // Output register: filled when the program finishes, freed on a transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (publish) begin
         rsp_data_ff <= {plate_y, plate_x, servo_y, servo_x};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[hdl/taosf_checker.sv]
// Port-level checker for the observer block and its bind to the top level.
module taosf_checker
   import taosf_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [63:0]       req_tdata,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [63:0]       rsp_tdata,
   input logic              csr_psel,
   input logic              csr_penable,
   input logic              csr_pwrite,
   input logic [CSR_AW-1:0] csr_paddr,
   input logic [CSR_DW-1:0] csr_pwdata,
   input logic [CSR_DW-1:0] csr_prdata,
   input logic              csr_pready
);

   // After reset the block is ready and holds no result.
   assert property (@(posedge clock) reset |=> (req_tready && !rsp_tvalid))
      else $error("block not idle after reset");

   // An accepted sample keeps the input closed while it is computed.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input ready while a sample is in work");

   // A new result appears only at the end of a program run.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared outside a program run");

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed or dropped");

endmodule

bind two_axis_observer_state_feedback taosf_checker u_taosf_checker (.*);

[sim/two_axis_observer_state_feedback_tb.sv]
// Self-checking testbench for the two-axis state feedback block with its observer.
`timescale 1ns / 1ps

module two_axis_observer_state_feedback_tb
   import taosf_pkg::*;
();

   localparam int  SETTING_SETS   = 6;
   localparam int  TICKS_PER_SET  = 310;
   localparam int  CYCLE_LIMIT    = 1000000;
   localparam int  SETTLE_CYCLES  = 40;

   // One sample tick as it travels in req_tdata, ref_x in the lowest bits.
   typedef struct packed {
      logic [15:0] meas_y;
      logic [15:0] ref_y;
      logic [15:0] meas_x;
      logic [15:0] ref_x;
   } tick_type;

   // One result as it travels in rsp_tdata, servo_x in the lowest bits.
   typedef struct packed {
      logic [15:0] plate_y;
      logic [15:0] plate_x;
      logic [15:0] servo_y;
      logic [15:0] servo_x;
   } servo_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [63:0]       req_tdata = '0;     // ref_x, meas_x, ref_y, meas_y
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [63:0]       rsp_tdata;          // servo_x, servo_y, plate_x, plate_y
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // Register copies and observer estimates of the predictor.
   logic [47:0]        gains_q;
   logic [31:0]        row0_q;
   logic [31:0]        row1_q;
   logic [31:0]        input_q;
   logic [31:0]        observer_q;
   logic [14:0]        limit_q;
   logic [15:0]        ratio_q;
   logic [1:0]         invert_q;
   logic signed [15:0] est [4];

   servo_result_type   expected_commands[$];
   int                 mismatch_count = 0;
   int                 cycle_count = 0;
   bit                 sender_gaps = 1'b0;
   logic               rx_throttle = 1'b0;
   int                 stall_left = 0;

   two_axis_observer_state_feedback u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("two_axis_observer_state_feedback_tb NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   // Signed Q3.12 field of a packed coefficient register.
   function automatic longint coef(input logic [47:0] word, input int pos);
      return longint'($signed(word[pos +: 16]));
   endfunction

   // Q11.24 to Q3.12: add half an LSB, then floor.
   function automatic longint round_q12(input longint acc);
      return (acc + 2048) >>> 12;
   endfunction

   function automatic longint clip16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // One axis of one tick: command, plate angle, clamp, observer update.
   function automatic void run_axis_model(input longint ref_pos, input longint meas_pos,
                                          input int base, input bit negate,
                                          output logic [15:0] servo,
                                          output logic [15:0] plate);
      longint e0, e1, lim, cmd, clamped, ang, innov, n0, n1;
      e0  = est[base];
      e1  = est[base + 1];
      lim = limit_q;
      cmd = round_q12(coef(gains_q, 0) * ref_pos - coef(gains_q, 16) * meas_pos
                      - coef(gains_q, 32) * e1);
      if (negate) cmd = -cmd;
      cmd = clip16(cmd);
      ang = clip16(round_q12(cmd * longint'($signed(ratio_q))));
      clamped = cmd;
      if (clamped > lim) clamped = lim;
      if (clamped < -lim) clamped = -lim;
      innov = meas_pos - e0;
      n0 = round_q12(coef(row0_q, 0) * e0 + coef(row0_q, 16) * e1
                     + coef(input_q, 0) * clamped + coef(observer_q, 0) * innov);
      n1 = round_q12(coef(row1_q, 0) * e0 + coef(row1_q, 16) * e1
                     + coef(input_q, 16) * clamped + coef(observer_q, 16) * innov);
      est[base]     = 16'(clip16(n0));
      est[base + 1] = 16'(clip16(n1));
      servo = 16'(clamped);
      plate = 16'(ang);
   endfunction

   function automatic servo_result_type predict_servo_tick(input tick_type t);
      servo_result_type res;
      logic [15:0]      sx, sy, px, py;
      run_axis_model(longint'($signed(t.ref_x)), longint'($signed(t.meas_x)), 0,
                     invert_q[0], sx, px);
      run_axis_model(longint'($signed(t.ref_y)), longint'($signed(t.meas_y)), 2,
                     invert_q[1], sy, py);
      res.servo_x = sx;
      res.servo_y = sy;
      res.plate_x = px;
      res.plate_y = py;
      return res;
   endfunction

   function automatic void load_reset_values();
      gains_q    = '0;
      row0_q     = '0;
      row1_q     = '0;
      input_q    = '0;
      observer_q = '0;
      limit_q    = 15'h7FFF;
      ratio_q    = 16'd4096;
      invert_q   = '0;
      for (int i = 0; i < 4; i++) est[i] = '0;
   endfunction

   // ---------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Every result transaction is compared with the oldest expectation.
   always @(posedge clock) begin
      servo_result_type got;
      servo_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_commands.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            mismatch_count++;
         end else begin
            want = expected_commands.pop_front();
            check_field("servo_x", want.servo_x, got.servo_x);
            check_field("servo_y", want.servo_y, got.servo_y);
            check_field("plate_x", want.plate_x, got.plate_x);
            check_field("plate_y", want.plate_y, got.plate_y);
         end
      end
   end

   // Receiver pacing: short stalls mostly, a few long ones, or none at all.
   always @(posedge clock) begin
      int roll;
      roll = $urandom_range(0, 99);
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (!rx_throttle) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (roll < 60) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         stall_left <= (roll < 93) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------

   function automatic int pick_gap();
      int roll;
      if (!sender_gaps) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic tick_type make_tick(input logic [15:0] rx, input logic [15:0] mx,
                                          input logic [15:0] ry, input logic [15:0] my);
      tick_type t;
      t.ref_x  = rx;
      t.meas_x = mx;
      t.ref_y  = ry;
      t.meas_y = my;
      return t;
   endfunction

   // Full-range, small, or extreme Q3.12 value.
   function automatic logic [15:0] pick_q16();
      int roll;
      int v;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 16'($urandom);
      if (roll < 85) begin
         v = $urandom_range(0, 4096);
         v = v - 2048;
         return 16'(v);
      end
      case ($urandom_range(0, 3))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         default: return 16'hFFFF;
      endcase
   endfunction

   // Coefficient: tame values keep the loop in range, wild ones push saturation.
   function automatic logic [15:0] pick_coef(input bit wild);
      int v;
      if (wild) return pick_q16();
      v = $urandom_range(0, 8192);
      v = v - 4096;
      return 16'(v);
   endfunction

   function automatic tick_type random_tick();
      return make_tick(pick_q16(), pick_q16(), pick_q16(), pick_q16());
   endfunction

   // Register write: setup cycle, then access cycle. The bus stays selected so
   // that writes can follow back to back; release_csr ends the burst.
   task automatic write_csr(input reg_index_type idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_CONTROL_GAINS:   gains_q    = value[47:0];
         REG_TRANSITION_ROW0: row0_q     = value[31:0];
         REG_TRANSITION_ROW1: row1_q     = value[31:0];
         REG_INPUT_GAINS:     input_q    = value[31:0];
         REG_OBSERVER_GAINS:  observer_q = value[31:0];
         REG_SERVO_LIMIT:     limit_q    = value[14:0];
         REG_PLATE_RATIO:     ratio_q    = value[15:0];
         REG_INVERT_MASK:     invert_q   = value[1:0];
         default: ;
      endcase
   endtask

   task automatic release_csr();
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Writes every register; unused upper bits carry random junk.
   task automatic write_settings(input logic [15:0] gref, input logic [15:0] k0,
                                 input logic [15:0] k1, input logic [15:0] f00,
                                 input logic [15:0] f01, input logic [15:0] f10,
                                 input logic [15:0] f11, input logic [15:0] g0,
                                 input logic [15:0] g1, input logic [15:0] l0,
                                 input logic [15:0] l1, input logic [14:0] lim,
                                 input logic [15:0] ratio, input logic [1:0] mask);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      write_csr(REG_CONTROL_GAINS,   {junk[63:48], k1, k0, gref});
      write_csr(REG_TRANSITION_ROW0, {junk[63:32], f01, f00});
      write_csr(REG_TRANSITION_ROW1, {junk[31:0], f11, f10});
      write_csr(REG_INPUT_GAINS,     {junk[47:16], g1, g0});
      write_csr(REG_OBSERVER_GAINS,  {junk[63:32], l1, l0});
      write_csr(REG_SERVO_LIMIT,     {junk[63:15], lim});
      write_csr(REG_PLATE_RATIO,     {junk[63:16], ratio});
      write_csr(REG_INVERT_MASK,     {junk[63:2], mask});
      release_csr();
   endtask

   // Offers one tick and records its expected result once it is accepted.
   task automatic send_tick(input tick_type t);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_commands.push_back(predict_servo_tick(t));
   endtask

   // Holds the sender until every outstanding result has come back.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_commands.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // With reset values all gains are zero, so every output stays zero.
   task automatic test_reset_values();
      send_tick(make_tick(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF));
      send_tick(make_tick(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000));
      send_tick(make_tick(16'h0001, 16'h1234, 16'h7FFF, 16'h8000));
      send_tick(make_tick(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA));
      wait_for_results();
   endtask

   // Command and plate angle saturation, including negation of the most
   // negative command.
   task automatic test_command_saturation();
      write_settings(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h0,
                     16'h0, 16'h0, 16'h0, 16'h0, 15'h7FFF, 16'h7FFF, 2'b00);
      send_tick(make_tick(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000));
      send_tick(make_tick(16'h8000, 16'h8000, 16'h7FFF, 16'h0000));
      send_tick(make_tick(16'h0000, 16'h0001, 16'hFFFF, 16'hFFFF));
      wait_for_results();
      write_settings(16'd4096, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                     16'h0, 16'h0, 16'h0, 16'h0, 15'h7FFF, 16'h8000, 2'b11);
      send_tick(make_tick(16'h8000, 16'h0000, 16'h7FFF, 16'h0000));
      send_tick(make_tick(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
      send_tick(make_tick(16'h0001, 16'h0000, 16'hFFFF, 16'h0000));
      send_tick(make_tick(16'h0800, 16'h0000, 16'hF800, 16'h0000));
      wait_for_results();
   endtask

   // Servo limit of zero, a middle limit, and the largest limit against the
   // most negative command.
   task automatic test_servo_clamp();
      write_settings(16'd4096, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                     16'h0, 16'h0, 16'h0, 16'h0, 15'd0, 16'd4096, 2'b00);
      send_tick(make_tick(16'd1234, 16'h0, 16'h8000, 16'h0));
      wait_for_results();
      write_csr(REG_SERVO_LIMIT, 64'd1000);
      release_csr();
      send_tick(make_tick(16'd5000, 16'h0, -16'sd5000, 16'h0));
      send_tick(make_tick(16'd500, 16'h0, 16'd1000, 16'h0));
      send_tick(make_tick(16'd1001, 16'h0, -16'sd1001, 16'h0));
      wait_for_results();
      write_csr(REG_SERVO_LIMIT, 64'h7FFF);
      release_csr();
      send_tick(make_tick(16'h8000, 16'h0, 16'h7FFF, 16'h0));
      wait_for_results();
   endtask

   // Drives the observer into saturation in both directions, with the
   // innovation at its full 17-bit swing.
   task automatic test_estimate_saturation();
      write_settings(16'd2048, 16'd1024, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                     16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 15'h7FFF,
                     16'd4096, 2'b10);
      send_tick(make_tick(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
      send_tick(make_tick(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000));
      send_tick(make_tick(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));
      send_tick(make_tick(16'h0000, 16'h7FFF, 16'h0000, 16'h8000));
      send_tick(make_tick(16'h1000, 16'h8000, 16'hF000, 16'h7FFF));
      send_tick(make_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000));
      wait_for_results();
   endtask

   // Several register settings, each followed by a long run of random ticks.
   task automatic test_random_settings();
      bit wild;
      for (int s = 0; s < SETTING_SETS; s++) begin
         wild = (s == 1) || (s == 3);
         case (s)
            // A plausible, stable loop with moderate gains.
            0, 5: write_settings(16'd4096, 16'd2048, 16'd1024, 16'd4096, 16'd410,
                                 16'd0, 16'd4096, 16'd0, 16'd410, 16'd1638, 16'd819,
                                 15'($urandom_range(1, 32767)),
                                 16'($urandom_range(1024, 8192)),
                                 (s == 5) ? 2'b11 : 2'b00);
            default: write_settings(pick_coef(wild), pick_coef(wild), pick_coef(wild),
                                    pick_coef(wild), pick_coef(wild), pick_coef(wild),
                                    pick_coef(wild), pick_coef(wild), pick_coef(wild),
                                    pick_coef(wild), pick_coef(wild),
                                    (s == 1) ? 15'h7FFF : (s == 2) ? 15'd0
                                       : 15'($urandom),
                                    (s == 1) ? 16'h8000 : (s == 2) ? 16'h7FFF
                                       : 16'($urandom),
                                    (s == 4) ? 2'($urandom) : 2'(s));
         endcase
         for (int n = 0; n < TICKS_PER_SET; n++) begin
            if (n % 64 == 0) begin
               sender_gaps = $urandom_range(0, 3) != 0;
               rx_throttle <= $urandom_range(0, 3) != 0;
            end
            if (n == TICKS_PER_SET / 2 && s % 2 == 0) wait_for_results();
            send_tick(random_tick());
         end
         wait_for_results();
      end
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      load_reset_values();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      rx_throttle <= 1'b1;
      sender_gaps = 1'b1;
      test_command_saturation();
      test_servo_clamp();
      test_estimate_saturation();
      test_random_settings();

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_commands.size() == 0) begin
         $display("two_axis_observer_state_feedback_tb OK");
      end else begin
         $display("two_axis_observer_state_feedback_tb NOT OK");
      end
      $finish;
   end

endmodule

[files.f]
hdl/taosf_pkg.sv
hdl/taosf_csr.sv
hdl/taosf_seq.sv
hdl/taosf_lane.sv
hdl/two_axis_observer_state_feedback.sv
hdl/taosf_checker.sv
sim/two_axis_observer_state_feedback_tb.sv
